// File: hw/rtl/upt_pkg.sv
// upt_pkg: types and constants shared by the user page table walker files
// opcodes, entry flag bits, request/response transfer structs, memory port structs
// no dependencies

package upt_pkg;

    // fixed table geometry of two-level 32-bit paging
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = 10;
    localparam int WORD_W        = 30;

    // request opcodes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_CHECK  = 3'd1;
    localparam logic [2:0] OP_MAP    = 3'd2;
    localparam logic [2:0] OP_UNMAP  = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // entry flag bits
    localparam logic [31:0] F_PRESENT = 32'h0000_0001;
    localparam logic [31:0] F_WRITE   = 32'h0000_0002;
    localparam logic [31:0] F_USER    = 32'h0000_0004;
    localparam logic [31:0] F_NEED    = F_PRESENT | F_WRITE | F_USER;
    localparam logic [31:0] PG_MASK   = 32'hFFFF_F000;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // input transfer
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] dir_base;
        logic [31:0] virtual_address;
        logic [31:0] phys_address;
        logic [11:0] entry_flags;
        logic [31:0] new_table_base;
        logic [31:0] write_data;
    } t_req;

    // result transfer
    typedef struct packed {
        logic        status;
        logic [31:0] result_value;
        logic        user_writable;
    } t_rsp;

    // memory port access, word number before wrap to the memory size
    typedef struct packed {
        logic              vld;
        logic              we;
        logic [WORD_W-1:0] word;
        logic [31:0]       data;
    } t_mem_req;

    // memory port read return
    typedef struct packed {
        logic        vld;
        logic [31:0] data;
    } t_mem_rsp;

endpackage

// File: hw/rtl/user_page_table_walker_core.sv
// user_page_table_walker_core: top level, walk sequencer over the physical memory port
// depends on upt_pkg, upt_mem_port (which holds upt_ram)
//
// channel   direction  transfer marker         payload
// request   in         start high, busy low    i_req  (upt_pkg::t_req)
// result    out        o_strobe, one cycle     o_rsp  (upt_pkg::t_rsp)
//
// the memory port takes one access per cycle; read data passes its stage and ram registers
// raw write: result in the cycle after start; raw read and walks: result after the last read
// map installing a new table: pde write as the read returns, sweep of all 1024 entries, pte write
// reset clears only control state; the memory needs no clearing pass
// the receiver cannot stall: results appear for one cycle and start is taken while idle

module user_page_table_walker_core #(
    parameter int MEM_WORDS      = 65536,
    parameter int USER_FIRST_DIR = 4,
    parameter int USER_END_DIR   = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  upt_pkg::t_req i_req,
    output logic          o_strobe,
    output upt_pkg::t_rsp o_rsp
);

    import upt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RAW   = 3'd1;
    localparam logic [2:0] S_PDE   = 3'd2;
    localparam logic [2:0] S_PTE   = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_MAPW  = 3'd5;

    localparam logic [IDX_W-1:0] CNT_LAST  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W:0]   DIR_FIRST = (IDX_W + 1)'(USER_FIRST_DIR);
    localparam logic [IDX_W:0]   DIR_END   = (IDX_W + 1)'(USER_END_DIR);

    logic [2:0]       r_state, n_state;
    t_req             r_req, n_req;
    logic [31:0]      r_pde, n_pde;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;
    t_rsp             r_rsp, n_rsp;

    t_mem_req         mem_req;
    t_mem_rsp         mem_rsp;
    logic             in_range;
    logic [31:0]      map_pte;

    // user directory range check on the incoming request
    assign in_range = ({1'b0, i_req.virtual_address[31:22]} >= DIR_FIRST) &&
                      ({1'b0, i_req.virtual_address[31:22]} <  DIR_END);

    // table entry written by a successful map
    assign map_pte = (r_req.phys_address & PG_MASK) |
                     {20'd0, r_req.entry_flags} | F_PRESENT;

    // walk sequencer
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_pde        = r_pde;
        n_cnt        = r_cnt;
        n_strobe     = 1'b0;
        n_rsp        = '{status: ST_FAIL, result_value: 32'd0, user_writable: 1'b0};
        mem_req      = '{vld: 1'b0, we: 1'b0, word: '0, data: 32'd0};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    case (i_req.opcode)
                        OP_LOOKUP, OP_CHECK, OP_UNMAP: begin
                            mem_req.vld  = 1'b1;
                            mem_req.word = {i_req.dir_base[31:12],
                                            i_req.virtual_address[31:22]};
                            n_state      = S_PDE;
                        end
                        OP_MAP: begin
                            if (in_range) begin
                                mem_req.vld  = 1'b1;
                                mem_req.word = {i_req.dir_base[31:12],
                                                i_req.virtual_address[31:22]};
                                n_state      = S_PDE;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            mem_req.vld  = 1'b1;
                            mem_req.we   = 1'b1;
                            mem_req.word = i_req.phys_address[31:2];
                            mem_req.data = i_req.write_data;
                            n_strobe     = 1'b1;
                            n_rsp.status = ST_OK;
                        end
                        OP_READ: begin
                            mem_req.vld  = 1'b1;
                            mem_req.word = i_req.phys_address[31:2];
                            n_state      = S_RAW;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_RAW: begin
                if (mem_rsp.vld) begin
                    n_strobe           = 1'b1;
                    n_rsp.status       = ST_OK;
                    n_rsp.result_value = mem_rsp.data;
                    n_state            = S_IDLE;
                end
            end
            S_PDE: begin
                if (mem_rsp.vld) begin
                    n_pde = mem_rsp.data;
                    case (r_req.opcode)
                        OP_CHECK: begin
                            if ((mem_rsp.data & F_NEED) == F_NEED) begin
                                mem_req.vld  = 1'b1;
                                mem_req.word = {mem_rsp.data[31:12],
                                                r_req.virtual_address[21:12]};
                                n_state      = S_PTE;
                            end else begin
                                n_strobe     = 1'b1;
                                n_rsp.status = ST_OK;
                                n_state      = S_IDLE;
                            end
                        end
                        OP_MAP: begin
                            if (mem_rsp.data[0]) begin
                                mem_req.vld  = 1'b1;
                                mem_req.word = {mem_rsp.data[31:12],
                                                r_req.virtual_address[21:12]};
                                n_state      = S_PTE;
                            end else if (r_req.new_table_base == 32'd0) begin
                                n_strobe = 1'b1;
                                n_state  = S_IDLE;
                            end else begin
                                // install the new table, then sweep it clear
                                mem_req.vld  = 1'b1;
                                mem_req.we   = 1'b1;
                                mem_req.word = {r_req.dir_base[31:12],
                                                r_req.virtual_address[31:22]};
                                mem_req.data = r_req.new_table_base | F_NEED;
                                n_cnt        = '0;
                                n_state      = S_CLEAR;
                            end
                        end
                        default: begin
                            // lookup and unmap need a present directory entry
                            if (mem_rsp.data[0]) begin
                                mem_req.vld  = 1'b1;
                                mem_req.word = {mem_rsp.data[31:12],
                                                r_req.virtual_address[21:12]};
                                n_state      = S_PTE;
                            end else begin
                                n_strobe = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_PTE: begin
                if (mem_rsp.vld) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    case (r_req.opcode)
                        OP_LOOKUP: begin
                            if ((mem_rsp.data & (F_PRESENT | F_USER)) ==
                                (F_PRESENT | F_USER)) begin
                                n_rsp.status       = ST_OK;
                                n_rsp.result_value = mem_rsp.data & PG_MASK;
                            end
                        end
                        OP_CHECK: begin
                            n_rsp.status        = ST_OK;
                            n_rsp.user_writable = ((mem_rsp.data & F_NEED) == F_NEED);
                        end
                        OP_MAP: begin
                            if (!mem_rsp.data[0]) begin
                                mem_req.vld  = 1'b1;
                                mem_req.we   = 1'b1;
                                mem_req.word = {r_pde[31:12], r_req.virtual_address[21:12]};
                                mem_req.data = map_pte;
                                n_rsp.status = ST_OK;
                            end
                        end
                        default: begin
                            // unmap clears a present entry
                            if (mem_rsp.data[0]) begin
                                mem_req.vld  = 1'b1;
                                mem_req.we   = 1'b1;
                                mem_req.word = {r_pde[31:12], r_req.virtual_address[21:12]};
                                n_rsp.status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                mem_req.vld  = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.word = {r_req.new_table_base[31:12], r_cnt};
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_MAPW;
                end
            end
            S_MAPW: begin
                // fresh table is all zero, so the entry is free
                mem_req.vld  = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.word = {r_req.new_table_base[31:12], r_req.virtual_address[21:12]};
                mem_req.data = map_pte;
                n_strobe     = 1'b1;
                n_rsp.status = ST_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_pde <= n_pde;
        r_cnt <= n_cnt;
        r_rsp <= n_rsp;
    end

    upt_mem_port #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem_port (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef ASSERT_OFF
    // every finished walk returns to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result transfer while busy");

    // read data only returns while a read is awaited
    a_rsp_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_rsp.vld |-> (r_state == S_RAW || r_state == S_PDE || r_state == S_PTE))
        else $error("memory read data with no read outstanding");

    // the clearing sweep writes zeros only
    a_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (mem_req.vld && mem_req.we && mem_req.data == 32'd0))
        else $error("clearing sweep issued something other than a zero write");

    // a raw read waits for its data
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.opcode == OP_READ) |=> (r_state == S_RAW))
        else $error("raw read did not wait for memory data");
`endif

endmodule

// File: hw/rtl/upt_ram.sv
// upt_ram: generic single-port synchronous ram with registered read
// width and depth set by parameters; no dependencies

module upt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle, write or read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/upt_mem_port.sv
// upt_mem_port: in-order memory port, wraps word numbers to the memory size
// two-stage reciprocal reduction, then one upt_ram; depends on upt_pkg, upt_ram

module upt_mem_port #(
    parameter int MEM_WORDS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upt_pkg::t_mem_req i_req,
    output upt_pkg::t_mem_rsp o_rsp
);

    import upt_pkg::*;

    localparam int          AW      = $clog2(MEM_WORDS);
    localparam int          SH      = WORD_W + AW;
    localparam int          QW      = WORD_W + 1 - AW;
    localparam logic [63:0] RECIP64 = (64'd1 << SH) / 64'(MEM_WORDS);
    localparam logic [30:0] RECIP   = RECIP64[30:0];
    localparam logic [WORD_W-1:0] MW = WORD_W'(MEM_WORDS);

    logic [60:0]       prod;
    logic [WORD_W-1:0] qm;
    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] rem;

    logic              r_s1_vld;
    logic              r_s1_we;
    logic [WORD_W-1:0] r_s1_x;
    logic [QW-1:0]     r_s1_q;
    logic [31:0]       r_s1_data;

    logic              r_s2_vld;
    logic              r_s2_we;
    logic [AW-1:0]     r_s2_idx;
    logic [31:0]       r_s2_data;

    logic              r_rd_vld;
    logic [31:0]       rdata;

    // quotient estimate, low by at most one
    assign prod = 61'(i_req.word) * 61'(RECIP);

    // remainder with a single correction step
    assign qm   = WORD_W'(r_s1_q) * MW;
    assign diff = r_s1_x - qm;
    assign rem  = (diff >= MW) ? (diff - MW) : diff;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.vld;
            r_s2_vld <= r_s1_vld;
            r_rd_vld <= r_s2_vld & ~r_s2_we;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_s1_we   <= i_req.we;
        r_s1_x    <= i_req.word;
        r_s1_q    <= prod[SH +: QW];
        r_s1_data <= i_req.data;
        r_s2_we   <= r_s1_we;
        r_s2_idx  <= rem[AW-1:0];
        r_s2_data <= r_s1_data;
    end

    upt_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (r_s2_vld),
        .i_we    (r_s2_we),
        .i_addr  (r_s2_idx),
        .i_wdata (r_s2_data),
        .o_rdata (rdata)
    );

    assign o_rsp.vld  = r_rd_vld;
    assign o_rsp.data = rdata;

endmodule

// File: tb/user_page_table_walker_core_tb.sv
// user_page_table_walker_core_tb: self-checking testbench for the page table walker core
// shadow memory predicts every walk, map, unmap and raw word transfer; results checked in order
// depends on upt_pkg and user_page_table_walker_core

module user_page_table_walker_core_tb;

    import upt_pkg::*;

    localparam int unsigned MEM_WORDS      = 65536;
    localparam int unsigned USER_FIRST_DIR = 4;
    localparam int unsigned USER_END_DIR   = 512;
    localparam int unsigned RANDOM_ITEMS   = 750;
    localparam int unsigned CALM_ITEMS     = 120;
    localparam int unsigned MAX_TABLES     = 300;
    localparam int unsigned CYCLE_LIMIT    = 2_000_000;

    // opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // shadow of the physical memory and the queue of expected results
    class walk_scoreboard;
        bit [31:0]   mem_word  [MEM_WORDS];
        bit          mem_known [MEM_WORDS];
        t_rsp        expected_q[$];
        int unsigned errors;
        int unsigned walks;
        int unsigned raws;
        int unsigned tables;

        function int unsigned word_of(bit [31:0] addr);
            return (addr >> 2) % MEM_WORDS;
        endfunction

        function bit [31:0] rd(bit [31:0] addr);
            return mem_word[word_of(addr)];
        endfunction

        function void wr(bit [31:0] addr, bit [31:0] data);
            mem_word[word_of(addr)]  = data;
            mem_known[word_of(addr)] = 1'b1;
        endfunction

        function bit [31:0] dir_entry(t_req r);
            return (r.dir_base & PG_MASK) + 32'(r.virtual_address[31:22]) * 4;
        endfunction

        function bit [31:0] tab_entry(bit [31:0] pde, bit [31:0] va);
            return (pde & PG_MASK) + 32'(va[21:12]) * 4;
        endfunction

        function bit in_user_range(bit [9:0] di);
            return (di >= USER_FIRST_DIR) && (di < USER_END_DIR);
        endfunction

        // first word the request would read before it was ever written, and
        // whether a map would install (and clear) a new table
        function void walk_plan(t_req r, output bit need, output int unsigned word,
                                output bit clears);
            bit [31:0] pde;
            need   = 1'b0;
            word   = 0;
            clears = 1'b0;
            if (r.opcode inside {OP_LOOKUP, OP_CHECK, OP_MAP, OP_UNMAP}) begin
                word = word_of(dir_entry(r));
                if (!mem_known[word]) begin
                    need = 1'b1;
                    return;
                end
                pde = mem_word[word];
                if (r.opcode == OP_MAP && in_user_range(r.virtual_address[31:22]) &&
                    (pde & F_PRESENT) == 0) begin
                    clears = (r.new_table_base != 0);
                    return;
                end
                if ((pde & F_PRESENT) != 0) begin
                    word = word_of(tab_entry(pde, r.virtual_address));
                    need = !mem_known[word];
                end
            end else if (r.opcode == OP_READ) begin
                word = word_of(r.phys_address);
                need = !mem_known[word];
            end
        endfunction

        // predict the result of an accepted request and update the shadow memory
        function void note_request(t_req r);
            t_rsp      e;
            bit [31:0] pde;
            bit [31:0] pte;
            bit [31:0] ea;
            bit        ok;
            e.status        = ST_FAIL;
            e.result_value  = '0;
            e.user_writable = 1'b0;
            case (r.opcode)
                OP_LOOKUP: begin
                    walks++;
                    pde = rd(dir_entry(r));
                    if ((pde & F_PRESENT) != 0) begin
                        pte = rd(tab_entry(pde, r.virtual_address));
                        if ((pte & F_PRESENT) != 0 && (pte & F_USER) != 0) begin
                            e.status       = ST_OK;
                            e.result_value = pte & PG_MASK;
                        end
                    end
                end
                OP_CHECK: begin
                    walks++;
                    e.status = ST_OK;
                    pde = rd(dir_entry(r));
                    if ((pde & F_NEED) == F_NEED) begin
                        pte = rd(tab_entry(pde, r.virtual_address));
                        e.user_writable = ((pte & F_NEED) == F_NEED);
                    end
                end
                OP_MAP: begin
                    walks++;
                    if (in_user_range(r.virtual_address[31:22])) begin
                        ok  = 1'b1;
                        pde = rd(dir_entry(r));
                        // absent directory entry: fail with no table, else install the supplied table and clear it
                        if ((pde & F_PRESENT) == 0) begin
                            if (r.new_table_base == 0) begin
                                ok = 1'b0;
                            end else begin
                                pde = r.new_table_base | F_NEED;
                                wr(dir_entry(r), pde);
                                for (int k = 0; k < TABLE_ENTRIES; k++)
                                    wr((r.new_table_base & PG_MASK) + 32'(k) * 4, '0);
                                tables++;
                            end
                        end
                        if (ok) begin
                            ea = tab_entry(pde, r.virtual_address);
                            if ((rd(ea) & F_PRESENT) == 0) begin
                                wr(ea, (r.phys_address & PG_MASK) | 32'(r.entry_flags) |
                                       F_PRESENT);
                                e.status = ST_OK;
                            end
                        end
                    end
                end
                OP_UNMAP: begin
                    walks++;
                    pde = rd(dir_entry(r));
                    if ((pde & F_PRESENT) != 0) begin
                        ea = tab_entry(pde, r.virtual_address);
                        if ((rd(ea) & F_PRESENT) != 0) begin
                            wr(ea, '0);
                            e.status = ST_OK;
                        end
                    end
                end
                OP_WRITE: begin
                    raws++;
                    wr(r.phys_address, r.write_data);
                    e.status = ST_OK;
                end
                OP_READ: begin
                    raws++;
                    e.result_value = rd(r.phys_address);
                    e.status       = ST_OK;
                end
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(t_rsp a);
            t_rsp e;
            if (expected_q.size() == 0) begin
                $error("unexpected result: status %0b value %h writable %0b",
                       a.status, a.result_value, a.user_writable);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.status !== e.status) begin
                $error("status: expected %0b, got %0b", e.status, a.status);
                errors++;
            end
            if (a.result_value !== e.result_value) begin
                $error("result_value: expected %h, got %h", e.result_value, a.result_value);
                errors++;
            end
            if (a.user_writable !== e.user_writable) begin
                $error("user_writable: expected %0b, got %0b", e.user_writable,
                       a.user_writable);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_strobe;
    t_rsp        o_rsp;

    walk_scoreboard sb;
    int unsigned    cycle_count = 0;
    bit             idle_on     = 1'b1;
    bit             prime_zero  = 1'b1;
    bit [5:0]       dir_page [4];
    bit [9:0]       dir_idx_pool [8];
    bit [9:0]       ti_pool [16];

    user_page_table_walker_core #(
        .MEM_WORDS      (MEM_WORDS),
        .USER_FIRST_DIR (USER_FIRST_DIR),
        .USER_END_DIR   (USER_END_DIR)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_rsp);
    end

    // address of a page with random bits around it
    function automatic bit [31:0] page_entry(bit [5:0] pg);
        bit [31:0] noise;
        noise = $urandom;
        return {noise[31:18], pg, noise[11:0]};
    endfunction

    // a page outside the directory pages
    function automatic bit [5:0] table_page();
        bit [5:0] p;
        do p = 6'($urandom_range(0, 63));
        while (p >= dir_page[0] && p <= dir_page[3]);
        return p;
    endfunction

    function automatic t_req make_request(logic [2:0] op, logic [31:0] dir, logic [31:0] va,
                                          logic [31:0] pa, logic [11:0] flags,
                                          logic [31:0] ntab, logic [31:0] wd);
        t_req r;
        r.opcode          = op;
        r.dir_base        = dir;
        r.virtual_address = va;
        r.phys_address    = pa;
        r.entry_flags     = flags;
        r.new_table_base  = ntab;
        r.write_data      = wd;
        return r;
    endfunction

    // random request, mostly walks through the pooled directories and indexes
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        bit [31:0]   noise;
        bit [9:0]    di;
        bit [9:0]    ti;
        pick  = $urandom_range(0, 99);
        noise = $urandom;
        if (pick < 28 || pick >= 94) r.opcode = OP_MAP;
        else if (pick < 46)         r.opcode = OP_LOOKUP;
        else if (pick < 60)         r.opcode = OP_CHECK;
        else if (pick < 70)         r.opcode = OP_UNMAP;
        else if (pick < 80)         r.opcode = OP_WRITE;
        else if (pick < 90)         r.opcode = OP_READ;
        else                        r.opcode = pick[0] ? OP_SPARE7 : OP_SPARE6;
        r.dir_base = ($urandom_range(0, 19) == 0) ? $urandom
                                                  : page_entry(dir_page[$urandom_range(0, 3)]);
        di = ($urandom_range(0, 6) == 0) ? 10'($urandom) : dir_idx_pool[$urandom_range(0, 7)];
        // broken maps outside the user directory range
        if (pick >= 94)
            di = $urandom_range(0, 1) ? 10'($urandom_range(0, USER_FIRST_DIR - 1))
                                      : 10'($urandom_range(USER_END_DIR, 1023));
        ti = ($urandom_range(0, 2) == 0) ? 10'($urandom) : ti_pool[$urandom_range(0, 15)];
        r.virtual_address = {di, ti, noise[11:0]};
        r.phys_address = $urandom;
        if ((r.opcode == OP_READ || r.opcode == OP_WRITE) && $urandom_range(0, 1))
            r.phys_address = {noise[31:18], dir_page[$urandom_range(0, 3)],
                              dir_idx_pool[$urandom_range(0, 7)], noise[1:0]};
        r.entry_flags = 12'($urandom);
        if ($urandom_range(0, 1))
            r.entry_flags = r.entry_flags | 12'(F_USER | F_WRITE);
        case ($urandom_range(0, 9))
            0:       r.new_table_base = '0;
            1:       r.new_table_base = $urandom;
            default: r.new_table_base = page_entry(table_page());
        endcase
        r.write_data = $urandom;
        return r;
    endfunction

    // one transfer: hold start until taken, then maybe idle for a burst
    task automatic send(t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk);
        while (busy);
        sb.note_request(r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // write any word the request would read unwritten, then send it
    task automatic issue(t_req r);
        t_req        w;
        bit          need;
        bit          clears;
        int unsigned word;
        sb.walk_plan(r, need, word, clears);
        while (need) begin
            w = make_request(OP_WRITE, $urandom, $urandom,
                             ($urandom & 32'hFFFC_0003) | (word << 2), 12'($urandom),
                             $urandom, '0);
            if (!prime_zero) begin
                case ($urandom_range(0, 4))
                    0, 1:    w.write_data = '0;
                    2, 3:    w.write_data = page_entry(table_page());
                    default: w.write_data = $urandom;
                endcase
            end
            send(w);
            sb.walk_plan(r, need, word, clears);
        end
        // keep the clearing sweeps within budget
        if (clears && sb.tables >= MAX_TABLES)
            r.new_table_base = '0;
        send(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk);
        while (sb.expected_q.size() != 0);
    endtask

    initial begin
        logic [31:0] dir_d;
        sb = new();
        dir_page[0] = 6'($urandom_range(8, 60));
        for (int k = 1; k < 4; k++)
            dir_page[k] = dir_page[0] + 6'(k);
        dir_idx_pool[0] = 10'(USER_FIRST_DIR);
        dir_idx_pool[1] = 10'(USER_END_DIR - 1);
        for (int k = 2; k < 8; k++)
            dir_idx_pool[k] = 10'($urandom_range(USER_FIRST_DIR, USER_END_DIR - 1));
        ti_pool[0] = 10'd0;
        ti_pool[1] = 10'd1023;
        for (int k = 2; k < 16; k++)
            ti_pool[k] = 10'($urandom);

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: raw access with wrap, map life cycle, range and flag cases
        dir_d = 32'hFFFC_1ABC;
        issue(make_request(OP_WRITE, '0, '0, 32'h0003_0000, '0, '0, 32'hFFFF_FFFF));
        issue(make_request(OP_READ, '0, '0, 32'hFFFF_0003, '0, '0, '0));
        issue(make_request(OP_WRITE, '0, '0, '0, '0, '0, '0));
        issue(make_request(OP_READ, '0, '0, '0, '0, '0, '0));
        issue(make_request(OP_MAP, dir_d, 32'h0100_0FFF, 32'hFFFF_FFFF, 12'hFFF, '0, '0));
        issue(make_request(OP_MAP, dir_d, 32'h0100_0FFF, 32'hFFFF_FFFF, 12'hFFF,
                           32'h0000_2FFF, '0));
        issue(make_request(OP_LOOKUP, dir_d, 32'h0100_0FFF, '0, '0, '0, '0));
        issue(make_request(OP_CHECK, dir_d, 32'h0100_0FFF, '0, '0, '0, '0));
        issue(make_request(OP_MAP, dir_d, 32'h0100_0000, 32'h1111_1000, 12'h006,
                           32'h0000_4000, '0));
        issue(make_request(OP_UNMAP, dir_d, 32'h0100_0000, '0, '0, '0, '0));
        issue(make_request(OP_UNMAP, dir_d, 32'h0100_0000, '0, '0, '0, '0));
        issue(make_request(OP_LOOKUP, dir_d, 32'h0100_0000, '0, '0, '0, '0));
        issue(make_request(OP_CHECK, dir_d, 32'h0100_0000, '0, '0, '0, '0));
        issue(make_request(OP_MAP, dir_d, 32'h0100_0000, '0, 12'h000, '0, '0));
        issue(make_request(OP_LOOKUP, dir_d, 32'h0100_0000, '0, '0, '0, '0));
        issue(make_request(OP_MAP, dir_d, 32'h00C0_0000, 32'h2222_2000, 12'h007,
                           32'h0000_5000, '0));
        issue(make_request(OP_MAP, dir_d, 32'h8000_0000, 32'h2222_2000, 12'h007,
                           32'h0000_5000, '0));
        issue(make_request(OP_MAP, dir_d, 32'h7FFF_F000, 32'h1234_5000, 12'h006,
                           32'h0000_3000, '0));
        issue(make_request(OP_CHECK, dir_d, 32'h7FFF_F000, '0, '0, '0, '0));
        // unmap below the user range goes through a hand-made directory entry
        issue(make_request(OP_WRITE, '0, '0, 32'h0000_1000, '0, '0, 32'h0000_3007));
        issue(make_request(OP_UNMAP, dir_d, 32'h003F_F000, '0, '0, '0, '0));
        issue(make_request(OP_LOOKUP, dir_d, 32'h7FFF_F000, '0, '0, '0, '0));
        issue(make_request(OP_SPARE6, $urandom, $urandom, $urandom, 12'($urandom),
                           $urandom, $urandom));
        issue(make_request(OP_SPARE7, $urandom, $urandom, $urandom, 12'($urandom),
                           $urandom, $urandom));
        drain();

        // random: walks over pooled directories, with noise and broken maps
        prime_zero = 1'b0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            if (n == RANDOM_ITEMS / 2)
                drain();
            issue(random_request());
        end

        // end of run
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        $display("run covered %0d walks and %0d raw word transfers, %0d new tables cleared",
                 sb.walks, sb.raws, sb.tables);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
